// File: design/assert_macros.svh
// Assertion macros used by the month statistics design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BMMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BMMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bmms_pkg.sv
// Types, constants and the month length table for the month statistics block.
package bmms_pkg;

  localparam int NUM_BINS   = 12;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int YEAR_W     = 16;
  localparam int FIELD_W    = 8;
  localparam int T_W        = 8;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 24;
  localparam int MEAN_W     = 16;
  localparam int TOT_W      = 20;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEAP_BITS  = 2;   // leap period of 4 years
  localparam int FRAC_W     = 8;   // Q8.8 mean
  localparam int DIV_STEPS  = 16;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int LEN_W      = 5;

  localparam logic [CNT_W-1:0]   BIN_FULL   = '1;
  localparam logic [TOT_W-1:0]   TOTAL_MAX  = '1;
  localparam logic [FIELD_W-1:0] HOUR_MAX   = 8'd23;
  localparam logic [FIELD_W-1:0] MINUTE_MAX = 8'd59;
  localparam logic [FIELD_W-1:0] MONTH_MIN  = 8'd1;
  localparam logic [FIELD_W-1:0] MONTH_MAX  = 8'(NUM_BINS);
  localparam logic [BIN_W-1:0]   BIN_FEB    = 4'd1;

  localparam logic signed [T_W-1:0] TEMP_LO_RST = -8'sd99;
  localparam logic signed [T_W-1:0] TEMP_HI_RST = 8'sd99;
  localparam logic [YEAR_W-1:0]     YEAR_LO_RST = 16'd1970;
  localparam logic [YEAR_W-1:0]     YEAR_HI_RST = 16'd2099;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LO = 2'd0,
    CFG_TEMP_HI = 2'd1,
    CFG_YEAR_LO = 2'd2,
    CFG_YEAR_HI = 2'd3
  } cfg_idx_t;

  // Days in the month held by a bin; February grows by one in a leap year.
  function automatic logic [LEN_W-1:0] month_len(input logic [BIN_W-1:0] bin,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    case (bin)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/bmms_ifs.sv
// Record and result channel interfaces for the month statistics block.
interface bmms_in_if;
  logic                                valid;
  logic                                ready;
  logic [bmms_pkg::YEAR_W-1:0]         rec_year;
  logic [bmms_pkg::FIELD_W-1:0]        rec_month;
  logic [bmms_pkg::FIELD_W-1:0]        rec_day;
  logic [bmms_pkg::FIELD_W-1:0]        rec_hour;
  logic [bmms_pkg::FIELD_W-1:0]        rec_minute;
  logic signed [bmms_pkg::T_W-1:0]     reading;

  modport source (output valid, rec_year, rec_month, rec_day, rec_hour, rec_minute,
                  reading, input ready);
  modport sink (input valid, rec_year, rec_month, rec_day, rec_hour, rec_minute,
                reading, output ready);
endinterface

interface bmms_out_if;
  logic                                valid;
  logic                                ready;
  bmms_pkg::status_t                   status;
  logic [bmms_pkg::CNT_W-1:0]          bin_count_out;
  logic signed [bmms_pkg::T_W-1:0]     bin_minimum;
  logic signed [bmms_pkg::T_W-1:0]     bin_maximum;
  logic signed [bmms_pkg::MEAN_W-1:0]  bin_mean;
  logic signed [bmms_pkg::T_W-1:0]     year_minimum;
  logic signed [bmms_pkg::T_W-1:0]     year_maximum;
  logic [bmms_pkg::TOT_W-1:0]          accepted_count;

  modport source (output valid, status, bin_count_out, bin_minimum, bin_maximum,
                  bin_mean, year_minimum, year_maximum, accepted_count, input ready);
  modport sink (input valid, status, bin_count_out, bin_minimum, bin_maximum,
                bin_mean, year_minimum, year_maximum, accepted_count, output ready);
endinterface

// File: design/binned_min_max_mean_stats.sv
// Month binned temperature statistics: validation, bin update and Q8.8 mean divider.
//
// Usage
//   in_ch  : one temperature record per word (year, month, day, hour, minute,
//            reading). in_ch.ready is high only while the block is idle.
//   out_ch : one result word per record: status, the month bin's count, min,
//            max and Q8.8 mean after the update, year min/max, accepted total.
//   cfg_*  : write port for the temperature and year limits, written while idle.
// Operation
//   After acceptance a record passes through check and reload, then the shared
//   shift-subtract divider that forms sum*256/count, one quotient bit a cycle,
//   and then finish, where the result is loaded. The divider is skipped when the
//   bin is empty or the month is out of range. The next record is taken only
//   after the result of the last one is loaded.
// Reset
//   rst_n clears all bins, the year extremes and the total and sets the limits to
//   their defaults; no clearing pass is needed.
// Back-pressure
//   A result waits in the output register until out_ch.ready; the next record
//   is still taken and held in its finish step until the register is free.
`include "assert_macros.svh"

module binned_min_max_mean_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bmms_in_if.sink                             in_ch,
  bmms_out_if.source                          out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Limit registers
  logic signed [bmms_pkg::T_W-1:0] temp_lo_r, temp_hi_r;
  logic [bmms_pkg::YEAR_W-1:0]     year_lo_r, year_hi_r;

  // Held record
  logic [bmms_pkg::YEAR_W-1:0]     year_r;
  logic [bmms_pkg::FIELD_W-1:0]    month_r, day_r, hour_r, minute_r;
  logic signed [bmms_pkg::T_W-1:0] reading_r;

  // Bin store and year statistics
  logic [bmms_pkg::CNT_W-1:0]        cnt_mem_r [bmms_pkg::NUM_BINS];
  logic signed [bmms_pkg::SUM_W-1:0] sum_mem_r [bmms_pkg::NUM_BINS];
  logic signed [bmms_pkg::T_W-1:0]   min_mem_r [bmms_pkg::NUM_BINS];
  logic signed [bmms_pkg::T_W-1:0]   max_mem_r [bmms_pkg::NUM_BINS];
  logic signed [bmms_pkg::T_W-1:0]   ymin_r, ymax_r;
  logic [bmms_pkg::TOT_W-1:0]        total_r;

  // Work registers
  bmms_pkg::status_t               status_r;
  logic                            have_bin_r;
  logic [bmms_pkg::BIN_W-1:0]      bin_r;
  logic [bmms_pkg::CNT_W-1:0]      w_cnt_r;
  logic signed [bmms_pkg::T_W-1:0] w_min_r, w_max_r;
  logic                            neg_r;
  logic [bmms_pkg::CNT_W-1:0]      rem_r;
  logic [bmms_pkg::MEAN_W-1:0]     quo_r;
  logic [bmms_pkg::STEP_W-1:0]     step_r;

  // Output register
  logic                              out_valid_r;
  bmms_pkg::status_t                 o_status_r;
  logic [bmms_pkg::CNT_W-1:0]        o_cnt_r;
  logic signed [bmms_pkg::T_W-1:0]   o_min_r, o_max_r, o_ymin_r, o_ymax_r;
  logic signed [bmms_pkg::MEAN_W-1:0] o_mean_r;
  logic [bmms_pkg::TOT_W-1:0]        o_total_r;

  // ---------------------------------------------------------------------
  // Record check and bin update terms (used in S_CHECK)
  // ---------------------------------------------------------------------
  logic                              have_bin;
  logic [bmms_pkg::BIN_W-1:0]        bin_sel;
  logic [bmms_pkg::LEN_W-1:0]        day_limit;
  logic                              rec_valid;
  logic [bmms_pkg::CNT_W-1:0]        cur_cnt;
  logic signed [bmms_pkg::SUM_W-1:0] cur_sum;
  logic signed [bmms_pkg::T_W-1:0]   cur_min, cur_max;
  bmms_pkg::status_t                 status_c;
  logic signed [bmms_pkg::SUM_W-1:0] reading_ext;

  assign have_bin = (month_r >= bmms_pkg::MONTH_MIN) && (month_r <= bmms_pkg::MONTH_MAX);
  assign bin_sel  = have_bin ? (month_r[bmms_pkg::BIN_W-1:0] - 4'd1) : '0;
  // Leap February every fourth year
  assign day_limit = bmms_pkg::month_len(bin_sel,
                                         year_r[bmms_pkg::LEAP_BITS-1:0] == '0);

  assign rec_valid = (reading_r >= temp_lo_r) && (reading_r <= temp_hi_r) &&
                     (year_r >= year_lo_r) && (year_r <= year_hi_r) &&
                     (minute_r <= bmms_pkg::MINUTE_MAX) &&
                     (hour_r <= bmms_pkg::HOUR_MAX) && have_bin &&
                     (day_r <= {3'b000, day_limit});

  assign cur_cnt = cnt_mem_r[bin_sel];
  assign cur_sum = sum_mem_r[bin_sel];
  assign cur_min = min_mem_r[bin_sel];
  assign cur_max = max_mem_r[bin_sel];
  assign reading_ext = {{(bmms_pkg::SUM_W-bmms_pkg::T_W){reading_r[bmms_pkg::T_W-1]}},
                        reading_r};

  always_comb begin
    if (!rec_valid) begin
      status_c = bmms_pkg::ST_INVALID;
    end else if (cur_cnt == bmms_pkg::BIN_FULL) begin
      status_c = bmms_pkg::ST_FULL;
    end else begin
      status_c = bmms_pkg::ST_OK;
    end
  end

  // ---------------------------------------------------------------------
  // Divider set-up from the updated bin (used in S_LOAD)
  // ---------------------------------------------------------------------
  logic [bmms_pkg::CNT_W-1:0]        ld_cnt;
  logic signed [bmms_pkg::SUM_W-1:0] ld_sum;
  logic [bmms_pkg::SUM_W-1:0]        ld_mag;
  logic [bmms_pkg::SUM_W+bmms_pkg::FRAC_W-1:0] dividend;

  assign ld_cnt   = have_bin_r ? cnt_mem_r[bin_r] : '0;
  assign ld_sum   = sum_mem_r[bin_r];
  assign ld_mag   = ld_sum[bmms_pkg::SUM_W-1] ? (~ld_sum + 1'b1) : ld_sum;
  assign dividend = {ld_mag, {bmms_pkg::FRAC_W{1'b0}}};

  // ---------------------------------------------------------------------
  // Shared shift-subtract step: one quotient bit a cycle
  // ---------------------------------------------------------------------
  logic [bmms_pkg::CNT_W:0] div_sh;
  logic                     div_ge;
  logic [bmms_pkg::CNT_W:0] div_diff;

  assign div_sh   = {rem_r, quo_r[bmms_pkg::MEAN_W-1]};
  assign div_diff = div_sh - {1'b0, w_cnt_r};
  assign div_ge   = div_sh >= {1'b0, w_cnt_r};

  logic                              out_free;
  logic signed [bmms_pkg::MEAN_W-1:0] mean_c;

  assign out_free = !out_valid_r || out_ch.ready;
  assign mean_c   = (w_cnt_r == '0) ? '0 :
                    (neg_r ? (~quo_r + 1'b1) : quo_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = (ld_cnt == '0) ? S_FIN : S_DIV;
      S_DIV:   if (step_r == bmms_pkg::STEP_W'(bmms_pkg::DIV_STEPS - 1)) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      temp_lo_r   <= bmms_pkg::TEMP_LO_RST;
      temp_hi_r   <= bmms_pkg::TEMP_HI_RST;
      year_lo_r   <= bmms_pkg::YEAR_LO_RST;
      year_hi_r   <= bmms_pkg::YEAR_HI_RST;
      for (int i = 0; i < bmms_pkg::NUM_BINS; i++) begin
        cnt_mem_r[i] <= '0;
        sum_mem_r[i] <= '0;
        min_mem_r[i] <= '0;
        max_mem_r[i] <= '0;
      end
      ymin_r  <= '0;
      ymax_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;

      // Limit writes
      if (cfg_we) begin
        case (bmms_pkg::cfg_idx_t'(cfg_index))
          bmms_pkg::CFG_TEMP_LO: temp_lo_r <= cfg_wdata[bmms_pkg::T_W-1:0];
          bmms_pkg::CFG_TEMP_HI: temp_hi_r <= cfg_wdata[bmms_pkg::T_W-1:0];
          bmms_pkg::CFG_YEAR_LO: year_lo_r <= cfg_wdata[bmms_pkg::YEAR_W-1:0];
          bmms_pkg::CFG_YEAR_HI: year_hi_r <= cfg_wdata[bmms_pkg::YEAR_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken; the finish step reloads it instead
      if (out_valid_r && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          // Hold the record for the check
          if (in_ch.valid) begin
            year_r    <= in_ch.rec_year;
            month_r   <= in_ch.rec_month;
            day_r     <= in_ch.rec_day;
            hour_r    <= in_ch.rec_hour;
            minute_r  <= in_ch.rec_minute;
            reading_r <= in_ch.reading;
          end
        end
        S_CHECK: begin
          status_r   <= status_c;
          have_bin_r <= have_bin;
          bin_r      <= bin_sel;
          if (status_c == bmms_pkg::ST_OK) begin
            cnt_mem_r[bin_sel] <= cur_cnt + 1'b1;
            sum_mem_r[bin_sel] <= cur_sum + reading_ext;
            if (cur_cnt == '0 || reading_r < cur_min) min_mem_r[bin_sel] <= reading_r;
            if (cur_cnt == '0 || reading_r > cur_max) max_mem_r[bin_sel] <= reading_r;
            if (total_r == '0 || reading_r < ymin_r) ymin_r <= reading_r;
            if (total_r == '0 || reading_r > ymax_r) ymax_r <= reading_r;
            if (total_r != bmms_pkg::TOTAL_MAX) total_r <= total_r + 1'b1;
          end
        end
        S_LOAD: begin
          // Read back the updated bin and seed the divider
          w_cnt_r <= ld_cnt;
          w_min_r <= have_bin_r ? min_mem_r[bin_r] : '0;
          w_max_r <= have_bin_r ? max_mem_r[bin_r] : '0;
          neg_r   <= ld_sum[bmms_pkg::SUM_W-1];
          rem_r   <= dividend[bmms_pkg::SUM_W+bmms_pkg::FRAC_W-1 -: bmms_pkg::CNT_W];
          quo_r   <= dividend[bmms_pkg::MEAN_W-1:0];
          step_r  <= '0;
        end
        S_DIV: begin
          // Advance one quotient bit
          rem_r  <= div_ge ? div_diff[bmms_pkg::CNT_W-1:0] : div_sh[bmms_pkg::CNT_W-1:0];
          quo_r  <= {quo_r[bmms_pkg::MEAN_W-2:0], div_ge};
          step_r <= step_r + 1'b1;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_status_r  <= status_r;
            o_cnt_r     <= w_cnt_r;
            o_min_r     <= w_min_r;
            o_max_r     <= w_max_r;
            o_mean_r    <= mean_c;
            o_ymin_r    <= ymin_r;
            o_ymax_r    <= ymax_r;
            o_total_r   <= total_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.bin_count_out  = o_cnt_r;
  assign out_ch.bin_minimum    = o_min_r;
  assign out_ch.bin_maximum    = o_max_r;
  assign out_ch.bin_mean       = o_mean_r;
  assign out_ch.year_minimum   = o_ymin_r;
  assign out_ch.year_maximum   = o_ymax_r;
  assign out_ch.accepted_count = o_total_r;

  `BMMS_ASSERT(a_accept_to_check, clk, rst_n, (in_ch.valid && in_ch.ready) |=> (state_r == S_CHECK), "accepted word did not enter the check step")
  `BMMS_ASSERT(a_result_from_fin, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_FIN), "result loaded outside the finish step")
  `BMMS_ASSERT(a_ok_counts, clk, rst_n, (out_valid_r && o_status_r == bmms_pkg::ST_OK) |-> (o_total_r != '0), "accepted result with zero total")
  `BMMS_ASSERT(a_year_order, clk, rst_n, (ymin_r <= ymax_r), "year minimum above year maximum")

endmodule
